### sv/sdf_pkg.sv
// Package for the SD SPI command framer: job descriptor, frame constants
// and the byte-wise CRC7 update used by the byte sequencer (sdf_back).
// No dependencies.
package sdf_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [5:0] APP_CMD_INDEX  = 6'd55;
    localparam logic [5:0] STOP_CMD_INDEX = 6'd12;
    localparam logic [7:0] START_BITS     = 8'h40;
    localparam logic [7:0] STUFF_BYTE     = 8'hFF;
    localparam logic [6:0] CRC_POLY       = 7'h09;

    // byte position inside a frame
    localparam logic [2:0] POS_START = 3'd0;
    localparam logic [2:0] POS_ARG3  = 3'd1;
    localparam logic [2:0] POS_ARG2  = 3'd2;
    localparam logic [2:0] POS_ARG1  = 3'd3;
    localparam logic [2:0] POS_ARG0  = 3'd4;
    localparam logic [2:0] POS_CRC   = 3'd5;
    localparam logic [2:0] POS_STUFF = 3'd6;

    typedef struct packed {
        logic [5:0]  command_index;
        logic        app_command;
        logic        stuff;
        logic [31:0] argument;
    } sdf_job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } sdf_queue_status_t;

    typedef struct packed {
        logic busy;
        logic prefix;
    } sdf_back_status_t;

    // CRC7 (x^7 + x^3 + 1) advanced over one byte, MSB first
    function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in, input logic [7:0] data);
        logic [6:0] crc;
        logic       fb;
        crc = crc_in;
        for (int k = 7; k >= 0; k--)
        begin
            fb  = data[k] ^ crc[6];
            crc = {crc[5:0], 1'b0};
            if (fb)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

### sv/sdf_front.sv
// Front stage of the SD SPI command framer: accepts a request and
// classifies it into a job descriptor. Depends on sdf_pkg.
module sdf_front
    import sdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic [5:0]  command_index,
    input  logic        app_command,
    input  logic [31:0] argument,
    output logic        job_valid,
    input  logic        job_ready,
    output sdf_job_t    job
);

    logic     job_valid_reg;
    logic     job_valid_next;
    sdf_job_t job_reg;

    assign cmd_ready = !job_valid_reg || job_ready;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    always_comb
    begin
        job_valid_next = job_valid_reg;
        if (job_valid_reg && job_ready)
        begin
            job_valid_next = 1'b0;
        end
        if (cmd_valid && cmd_ready)
        begin
            job_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
        end
    end

    // stuff byte follows a plain stop command only
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            job_reg.command_index <= command_index;
            job_reg.app_command   <= app_command;
            job_reg.stuff         <= !app_command && (command_index == STOP_CMD_INDEX);
            job_reg.argument      <= argument;
        end
    end

endmodule

### sv/sdf_queue.sv
// Job queue between front and back of the SD SPI command framer.
// Small register FIFO. Depends on sdf_pkg.
module sdf_queue
    import sdf_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sdf_job_t          push_job,
    input  logic              pop,
    output sdf_job_t          head_job,
    output sdf_queue_status_t status
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    sdf_job_t           mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_job     = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### sv/sdf_back.sv
// Back part of the SD SPI command framer: sequences each job's frame
// bytes, computes CRC7 one byte per cycle unless stalled. Depends on sdf_pkg.
module sdf_back
    import sdf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              queue_empty,
    input  sdf_job_t          head_job,
    output logic              pop,
    output logic              byte_valid,
    input  logic              byte_ready,
    output logic [7:0]        line_byte,
    output logic              last_byte,
    output sdf_back_status_t  status
);

    sdf_job_t   job_reg;
    logic       busy_reg,   busy_next;
    logic       prefix_reg, prefix_next;
    logic [2:0] pos_reg,    pos_next;
    logic [6:0] crc_reg,    crc_next;
    logic       byte_valid_reg, byte_valid_next;
    logic [7:0] line_byte_reg;
    logic       last_byte_reg;

    logic [5:0]  cur_index;
    logic [31:0] cur_arg;
    logic [7:0]  cur_byte;
    logic        advance;
    logic        job_done;

    assign cur_index = prefix_reg ? APP_CMD_INDEX : job_reg.command_index;
    assign cur_arg   = prefix_reg ? 32'd0 : job_reg.argument;

    always_comb
    begin
        unique case (pos_reg)
            POS_START: cur_byte = START_BITS | {2'b00, cur_index};
            POS_ARG3:  cur_byte = cur_arg[31:24];
            POS_ARG2:  cur_byte = cur_arg[23:16];
            POS_ARG1:  cur_byte = cur_arg[15:8];
            POS_ARG0:  cur_byte = cur_arg[7:0];
            POS_CRC:   cur_byte = {crc_reg, 1'b1};
            default:   cur_byte = STUFF_BYTE;
        endcase
    end

    assign advance  = busy_reg && (!byte_valid_reg || byte_ready);
    assign job_done = ((pos_reg == POS_CRC) && !prefix_reg && !job_reg.stuff)
                      || (pos_reg == POS_STUFF);
    // next job loads when idle or as the prior one sends its final byte
    assign pop      = !queue_empty && (!busy_reg || (advance && job_done));

    always_comb
    begin
        busy_next       = busy_reg;
        prefix_next     = prefix_reg;
        pos_next        = pos_reg;
        crc_next        = crc_reg;
        byte_valid_next = byte_valid_reg && !byte_ready;
        if (advance)
        begin
            byte_valid_next = 1'b1;
            priority if (job_done)
            begin
                busy_next = 1'b0;
            end
            else if (pos_reg == POS_CRC && prefix_reg)
            begin
                prefix_next = 1'b0;
                pos_next    = POS_START;
                crc_next    = '0;
            end
            else if (pos_reg == POS_CRC)
            begin
                pos_next = POS_STUFF;
            end
            else
            begin
                pos_next = pos_reg + 3'd1;
                crc_next = crc7_byte(crc_reg, cur_byte);
            end
        end
        if (pop)
        begin
            busy_next   = 1'b1;
            prefix_next = head_job.app_command;
            pos_next    = POS_START;
            crc_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            prefix_reg     <= 1'b0;
            pos_reg        <= POS_START;
            crc_reg        <= '0;
            byte_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            prefix_reg     <= prefix_next;
            pos_reg        <= pos_next;
            crc_reg        <= crc_next;
            byte_valid_reg <= byte_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head_job;
        end
        if (advance)
        begin
            line_byte_reg <= cur_byte;
            last_byte_reg <= job_done;
        end
    end

    assign byte_valid    = byte_valid_reg;
    assign line_byte     = line_byte_reg;
    assign last_byte     = last_byte_reg;
    assign status.busy   = busy_reg;
    assign status.prefix = prefix_reg;

endmodule

### sv/sd_spi_command_framer_top.sv
// SD SPI command framer top level: front stage, job queue, byte sequencer.
// Depends on sdf_pkg, sdf_front, sdf_queue, sdf_back.
//
// Each request becomes the SPI bytes of an SD command frame: 0x40|index, the
// argument MSB first and the CRC7 byte with end bit; an application command
// gets a CMD55 frame first and a plain CMD12 a trailing 0xFF. The byte
// sequencer emits one byte per cycle while byte_ready does not stall it and
// computes the CRC7 one byte at a time. A request is 6, 7 or 12 bytes long;
// requests follow each other with no gap when the next one is already queued,
// and the job queue lets new requests be taken while the current one is
// still being sent. last_byte marks the final byte of each request.
module sd_spi_command_framer_top
    import sdf_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic [5:0]  command_index,
    input  logic        app_command,
    input  logic [31:0] argument,
    output logic        byte_valid,
    input  logic        byte_ready,
    output logic [7:0]  line_byte,
    output logic        last_byte
);

    logic              job_valid;
    logic              job_ready;
    sdf_job_t          front_job;
    sdf_job_t          head_job;
    logic              pop;
    sdf_queue_status_t q_status;
    sdf_back_status_t  bk_status;

    assign job_ready = !q_status.full;

    sdf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .command_index (command_index),
        .app_command   (app_command),
        .argument      (argument),
        .job_valid     (job_valid),
        .job_ready     (job_ready),
        .job           (front_job)
    );

    sdf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_valid),
        .push_job (front_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    sdf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (q_status.empty),
        .head_job    (head_job),
        .pop         (pop),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .line_byte   (line_byte),
        .last_byte   (last_byte),
        .status      (bk_status)
    );

    // final byte is a CRC byte or the stuff byte; both have bit 0 set
    a_last_has_end_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && last_byte) |-> line_byte[0])
        else $error("final byte without end bit");

    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue both full and empty");

    // a byte loaded from a CMD55 prefix frame never ends a request
    a_no_last_in_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (bk_status.busy && bk_status.prefix && (!byte_valid || byte_ready)) |=> !last_byte)
        else $error("last byte flagged inside prefix frame");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

endmodule
